/* rtl/shs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types and constant tables for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef word_t [15:0] block_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic hash_t iv_hash();
    hash_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = iv_word(3'(i));
    end
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/sha256_stream_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; emits the eight digest words per message.
// ----------------------------------------------------------------------------
// Input channel s_*: one message byte per word in s_tdata, s_tuser high when
// the byte is present, s_tlast on the last word of a message. A word with
// s_tlast and s_tuser low ends the message with no byte (empty message is
// allowed); a word with both low is ignored.
// Output channel m_*: eight words per message, digest word in m_tdata, its
// index in m_tuser (0 is most significant), m_tlast on index 7.
// Throughput: bytes that do not close a 64-byte block are taken at one per
// cycle. A byte that closes a block starts the round unit: 64 rounds at one
// per cycle, then the sum is folded into the chaining value, s_tready low.
// At the end of a message padding writes one byte per cycle and runs one or
// two more compressions; the digest then loads the output buffer and the
// next message may start while the digest drains.
// If the receiver stalls, the output words hold; a further message end
// waits until the buffer has drained.
// Reset clears the chaining value to the initial hash, the byte count and
// the fill position, and empties the output buffer.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] message_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_number
  output logic        m_tlast    // final_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  fill;
  logic [60:0] length;
  logic        pending_end;
  logic        pad_done;
  logic        final_blk;
  logic        start;
  block_t      block;
  hash_t       chain;
  hash_t       chain_sum;
  logic        core_done;
  hash_t       out_buf;
  logic        out_busy;
  logic [2:0]  out_idx;
  logic [63:0] bit_len;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_busy;
  assign m_tdata  = out_buf[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == 3'd7);
  assign bit_len  = {length, 3'b000};

  shs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .block     (block),
    .chain_in  (chain),
    .done      (core_done),
    .chain_out (chain_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      length      <= '0;
      pending_end <= 1'b0;
      pad_done    <= 1'b0;
      final_blk   <= 1'b0;
      start       <= 1'b0;
      chain       <= iv_hash();
      out_busy    <= 1'b0;
      out_idx     <= '0;
    end else begin
      start <= 1'b0;
      if (out_busy && m_tready) begin
        out_idx <= 3'(out_idx + 3'd1);
        if (out_idx == 3'd7) begin
          out_busy <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pending_end <= s_tlast;
            if (s_tuser) begin
              block[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= s_tdata;
              fill      <= 6'(fill + 6'd1);
              length    <= 61'(length + 61'd1);
              if (fill == LAST_POS) begin
                start <= 1'b1;
                state <= S_COMP;
              end else if (s_tlast) begin
                state <= S_PAD;
              end
            end else if (s_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (!pad_done || fill != LEN_POS) begin
            block[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= pad_done ? 8'h00 : PAD_BYTE;
            pad_done  <= 1'b1;
            fill      <= 6'(fill + 6'd1);
            if (fill == LAST_POS) begin
              start <= 1'b1;
              state <= S_COMP;
            end
          end else begin
            block[4'd14] <= bit_len[63:32];
            block[4'd15] <= bit_len[31:0];
            final_blk <= 1'b1;
            start     <= 1'b1;
            state     <= S_COMP;
          end
        end
        S_COMP: begin
          if (core_done) begin
            chain <= chain_sum;
            if (final_blk) begin
              state <= S_FIN;
            end else if (pending_end) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (!out_busy) begin
            out_buf     <= chain;
            out_busy    <= 1'b1;
            out_idx     <= '0;
            chain       <= iv_hash();
            fill        <= '0;
            length      <= '0;
            pad_done    <= 1'b0;
            final_blk   <= 1'b0;
            pending_end <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/shs_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_core
// SHA-256 compression unit: one round per cycle, 64 rounds, with a
// sixteen-word rolling message schedule; the chaining sum is shown on done.
// ----------------------------------------------------------------------------
module shs_core
  import shs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  block_t block,
  input  hash_t  chain_in,
  output logic   done,
  output hash_t  chain_out
);

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic        busy;
  logic [5:0]  round;
  word_t       w [16];
  hash_t       v;
  word_t       w_next;
  word_t       t1;
  word_t       t2;

  always_comb begin
    w_next = w[0]
           + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3))
           + w[9]
           + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    for (int i = 0; i < 8; i++) begin
      chain_out[i] = chain_in[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= 6'(round + 6'd1);
        if (round == LAST_POS) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= chain_in;
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[i];
      end
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_next;
      v[7]  <= v[6];
      v[6]  <= v[5];
      v[5]  <= v[4];
      v[4]  <= v[3] + t1;
      v[3]  <= v[2];
      v[2]  <= v[1];
      v[1]  <= v[0];
      v[0]  <= t1 + t2;
    end
  end

endmodule

/* rtl/shs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on the digest output channel of the stream hasher.
// ----------------------------------------------------------------------------
module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
    else $error("tlast does not match word index 7");

  a_next_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid
                                        && m_tuser == 3'($past(m_tuser) + 3'd1))
    else $error("digest words not back to back in order");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("new digest started right after the last word");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);
